### hdl/jac_pkg.sv
// Shared types and constants for the joystick axis calibrator.
// No dependencies.
package jac_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 14;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    typedef enum logic [2:0] {
        REG_CAL_MIN    = 3'd0,
        REG_CAL_MAX    = 3'd1,
        REG_CAL_ZERO   = 3'd2,
        REG_CAL_PRES   = 3'd3,
        REG_INVERT     = 3'd4,
        REG_THROTTLE   = 3'd5,
        REG_THR_SIGNED = 3'd6,
        REG_DEADZONE   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic have;   // calibration loaded
        logic inv;    // invert result
        logic thr;    // throttle handling
        logic ut;     // unsigned throttle path
    } t_mode;

endpackage

### hdl/jac_front.sv
// Front stages: range differences, then magnitudes and ratio special-case flags.
// Depends on jac_pkg.
module jac_front #(
    parameter int SAMPLE_BITS = jac_pkg::SAMPLE_BITS,
    parameter int FRAC_BITS   = jac_pkg::FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [SAMPLE_BITS-1:0] i_raw,
    input  logic signed [SAMPLE_BITS-1:0] i_min,
    input  logic signed [SAMPLE_BITS-1:0] i_max,
    input  logic signed [SAMPLE_BITS-1:0] i_zero,
    input  jac_pkg::t_mode                i_mode,
    input  logic [FRAC_BITS:0]            i_dz,
    output logic                          o_valid,
    output logic [SAMPLE_BITS:0]          o_an1,
    output logic [SAMPLE_BITS:0]          o_ad1,
    output logic [SAMPLE_BITS:0]          o_an2,
    output logic [SAMPLE_BITS:0]          o_ad2,
    output logic                          o_zero1,
    output logic                          o_full1,
    output logic                          o_zero2,
    output logic                          o_full2,
    output logic                          o_lin,
    output jac_pkg::t_mode                o_mode,
    output logic [FRAC_BITS:0]            o_dz
);
    localparam int D = SAMPLE_BITS + 1;

    function automatic logic [D-1:0] f_abs(input logic signed [D-1:0] v);
        f_abs = v[D-1] ? D'(-v) : D'(v);
    endfunction

    logic signed [D-1:0] w_raw, w_min, w_max, w_zero, w_cc;
    logic signed [D-1:0] n_n1, n_d1, n_n2, n_rng, n_zd;
    logic signed [D-1:0] r_n1, r_d1, r_n2, r_rng, r_zd;
    logic                r_vld1;
    jac_pkg::t_mode      r_mode1;
    logic [FRAC_BITS:0]  r_dz1;

    assign w_raw  = {i_raw[SAMPLE_BITS-1], i_raw};
    assign w_min  = {i_min[SAMPLE_BITS-1], i_min};
    assign w_max  = {i_max[SAMPLE_BITS-1], i_max};
    assign w_zero = {i_zero[SAMPLE_BITS-1], i_zero};

    always_comb begin
        if (w_zero < w_min) begin
            w_cc = w_min;
        end else if (w_zero < w_max) begin
            w_cc = w_zero;
        end else begin
            w_cc = w_max;
        end
        n_rng = w_max - w_min;
        n_zd  = w_zero - w_min;
        n_n2  = w_cc - w_min;
        n_n1  = i_mode.ut ? (w_raw - w_zero) : (w_raw - w_min);
        n_d1  = i_mode.ut ? (w_max - w_zero) : n_rng;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else begin
            r_vld1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n1    <= n_n1;
        r_d1    <= n_d1;
        r_n2    <= n_n2;
        r_rng   <= n_rng;
        r_zd    <= n_zd;
        r_mode1 <= i_mode;
        r_dz1   <= i_dz;
    end

    // stage 2
    logic [D-1:0] n_an1, n_ad1, n_an2, n_ad2;
    logic [D+1:0] w_zd4;
    logic         n_zero1, n_full1, n_zero2, n_full2, n_lin;

    always_comb begin
        n_an1   = f_abs(r_n1);
        n_ad1   = f_abs(r_d1);
        n_an2   = f_abs(r_n2);
        n_ad2   = f_abs(r_rng);
        n_zero1 = (r_d1 == '0) || (r_n1 == '0) || (r_n1[D-1] != r_d1[D-1]);
        n_zero2 = (r_rng == '0) || (r_n2 == '0) || (r_n2[D-1] != r_rng[D-1]);
        n_full1 = n_an1 >= n_ad1;
        n_full2 = n_an2 >= n_ad2;
        w_zd4   = {f_abs(r_zd), 2'b00};
        n_lin   = r_rng[D-1] || ((r_rng != '0) && (w_zd4 < {2'b00, r_rng}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        o_an1   <= n_an1;
        o_ad1   <= n_ad1;
        o_an2   <= n_an2;
        o_ad2   <= n_ad2;
        o_zero1 <= n_zero1;
        o_full1 <= n_full1;
        o_zero2 <= n_zero2;
        o_full2 <= n_full2;
        o_lin   <= n_lin;
        o_mode  <= r_mode1;
        o_dz    <= r_dz1;
    end

endmodule

### hdl/jac_div.sv
// Pipelined restoring divider, one quotient bit per stage: floor(num*2^Q/den), num < den.
// Carries a sideband vector alongside. Depends on nothing.
module jac_div #(
    parameter int W  = 17,
    parameter int Q  = 14,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [W-1:0]  i_num,
    input  logic [W-1:0]  i_den,
    input  logic [PW-1:0] i_side,
    output logic          o_valid,
    output logic [Q-1:0]  o_quot,
    output logic [PW-1:0] o_side
);
    logic          r_vld  [Q];
    logic [W-1:0]  r_rem  [Q];
    logic [W-1:0]  r_den  [Q];
    logic [Q-1:0]  r_quo  [Q];
    logic [PW-1:0] r_side [Q];

    for (genvar k = 0; k < Q; k++) begin : g_stage
        logic          w_vld_in;
        logic [W-1:0]  w_rem_in, w_den_in;
        logic [Q-1:0]  w_quo_in;
        logic [PW-1:0] w_side_in;
        logic [W:0]    w_shift;
        logic          n_ge;
        logic [W-1:0]  n_rem;

        if (k == 0) begin : g_first
            assign w_vld_in  = i_valid;
            assign w_rem_in  = i_num;
            assign w_den_in  = i_den;
            assign w_quo_in  = '0;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_vld_in  = r_vld[k-1];
            assign w_rem_in  = r_rem[k-1];
            assign w_den_in  = r_den[k-1];
            assign w_quo_in  = r_quo[k-1];
            assign w_side_in = r_side[k-1];
        end

        always_comb begin
            w_shift = {w_rem_in, 1'b0};
            n_ge    = w_shift >= {1'b0, w_den_in};
            n_rem   = n_ge ? W'(w_shift - {1'b0, w_den_in}) : W'(w_shift);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= n_rem;
            r_den[k]  <= w_den_in;
            r_quo[k]  <= {w_quo_in[Q-2:0], n_ge};
            r_side[k] <= w_side_in;
        end
    end

    assign o_valid = r_vld[Q-1];
    assign o_quot  = r_quo[Q-1];
    assign o_side  = r_side[Q-1];

endmodule

### hdl/jac_mid.sv
// Middle stages: resolve position and center ratios, pick side span and offset.
// Depends on jac_pkg parameters only through its own.
module jac_mid #(
    parameter int FRAC_BITS = jac_pkg::FRAC_BITS,
    parameter int SW        = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [FRAC_BITS-1:0] i_q1,
    input  logic [FRAC_BITS-1:0] i_q2,
    input  logic                 i_zero1,
    input  logic                 i_full1,
    input  logic                 i_zero2,
    input  logic                 i_full2,
    input  logic [SW-1:0]        i_side,
    output logic                 o_valid,
    output logic [FRAC_BITS:0]   o_num,
    output logic [FRAC_BITS:0]   o_span,
    output logic                 o_full,
    output logic                 o_neg,
    output logic [FRAC_BITS:0]   o_p,
    output logic [SW-1:0]        o_side
);
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [FRAC_BITS:0] LSB = {{FRAC_BITS{1'b0}}, 1'b1};

    logic [FRAC_BITS:0] n_p, n_c, n_lo, n_hi, w_hi;
    logic [FRAC_BITS:0] r_p, r_c, r_lo, r_hi;
    logic [SW-1:0]      r_side;
    logic               r_vld;

    always_comb begin
        n_p  = i_zero1 ? '0 : (i_full1 ? ONE : {1'b0, i_q1});
        n_c  = i_zero2 ? '0 : (i_full2 ? ONE : {1'b0, i_q2});
        n_lo = (n_c == '0) ? LSB : n_c;
        w_hi = ONE - n_c;
        n_hi = (w_hi == '0) ? LSB : w_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p    <= n_p;
        r_c    <= n_c;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_side <= i_side;
    end

    logic               n_neg, n_full;
    logic [FRAC_BITS:0] n_num, n_span;

    always_comb begin
        n_neg  = r_p < r_c;
        n_num  = n_neg ? (r_c - r_p) : (r_p - r_c);
        n_span = n_neg ? r_lo : r_hi;
        n_full = n_num >= n_span;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_num  <= n_num;
        o_span <= n_span;
        o_full <= n_full;
        o_neg  <= n_neg;
        o_p    <= r_p;
        o_side <= r_side;
    end

endmodule

### hdl/jac_back.sv
// Output stage: mode select, deadzone, inversion.
// Depends on jac_pkg.
module jac_back #(
    parameter int FRAC_BITS = jac_pkg::FRAC_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [FRAC_BITS-1:0]       i_q,
    input  logic                       i_full,
    input  logic                       i_neg,
    input  logic [FRAC_BITS:0]         i_p,
    input  jac_pkg::t_mode             i_mode,
    input  logic                       i_lin,
    input  logic [FRAC_BITS:0]         i_dz,
    output logic                       o_valid,
    output logic signed [FRAC_BITS+1:0] o_axis
);
    localparam int O = FRAC_BITS + 2;
    localparam logic [FRAC_BITS:0] ONE   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [O:0]         ONE_X = {2'b00, ONE};

    logic [FRAC_BITS:0]  w_amag, w_uv;
    logic signed [O-1:0] w_sa, w_lv, w_pre, w_sig, n_out;
    logic [O-1:0]        w_mag;
    logic [O:0]          w_lv_x;

    always_comb begin
        w_amag = i_full ? ONE : {1'b0, i_q};
        w_sa   = i_neg ? -$signed({1'b0, w_amag}) : $signed({1'b0, w_amag});
        w_lv_x = {1'b0, i_p, 1'b0} - ONE_X;
        w_lv   = $signed(w_lv_x[O-1:0]);
        w_pre  = (i_mode.thr && i_lin) ? w_lv : w_sa;
        w_mag  = w_pre[O-1] ? O'(-w_pre) : O'(w_pre);
        w_sig  = (!i_mode.have || (w_mag < {1'b0, i_dz})) ? '0 : w_pre;
        w_uv   = i_mode.have ? i_p : '0;
        if (i_mode.ut) begin
            n_out = i_mode.inv ? $signed({1'b0, ONE - w_uv}) : $signed({1'b0, w_uv});
        end else begin
            n_out = i_mode.inv ? -w_sig : w_sig;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_axis <= n_out;
    end

endmodule

### hdl/joystick_axis_calibrator.sv
// Joystick axis calibrator, top level: register file and pipeline assembly.
// Depends on jac_pkg, jac_front, jac_div, jac_mid, jac_back.
//
// Usage:
//   Raise start with i_raw_sample; the sample is taken on any clock edge with
//   start high and busy low. busy is always low, so one sample per cycle.
//   Each sample yields exactly one result: o_valid pulses for one cycle with
//   o_axis_out (Q1.FRAC_BITS, 1.0 = 2^FRAC_BITS), results in input order.
//   Each result passes through five stages of range, span and output logic and
//   restoring dividers of FRAC_BITS stages each: two in parallel for position
//   and center ratios, one for side rescale. Throughput: one per cycle.
//   The receiver cannot stall; results must be taken when o_valid is high.
//   Calibration registers sit on the APB port at byte address 4*index; write
//   them only while the pipeline is empty. pready is always high.
//   Reset (i_rst_n low, synchronous) empties the pipeline and restores the
//   registers: min/max span the full sample range, zero point 0, calibration
//   absent, deadzone 0.05 of full scale.
module joystick_axis_calibrator #(
    parameter int SAMPLE_BITS = jac_pkg::SAMPLE_BITS,
    parameter int FRAC_BITS   = jac_pkg::FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [SAMPLE_BITS-1:0] i_raw_sample,
    output logic                          o_valid,
    output logic signed [FRAC_BITS+1:0]   o_axis_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [jac_pkg::ADDR_W-1:0]    paddr,
    input  logic [jac_pkg::DATA_W-1:0]    pwdata,
    output logic [jac_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    localparam int D  = SAMPLE_BITS + 1;
    localparam int V  = FRAC_BITS + 1;
    localparam int MW = $bits(jac_pkg::t_mode);
    localparam int P1 = 3 + MW + V;
    localparam int SW = 1 + MW + V;
    localparam int P2 = 2 + V + SW;
    localparam int DZ_RESET = ((1 << FRAC_BITS) * 5) / 100;

    logic [SAMPLE_BITS-1:0] r_cal_min, r_cal_max, r_cal_zero;
    logic                   r_present, r_invert, r_throttle, r_thr_signed;
    logic [FRAC_BITS:0]     r_deadzone;
    jac_pkg::t_reg_idx      w_idx;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign w_idx  = jac_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_min    <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            r_cal_max    <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            r_cal_zero   <= '0;
            r_present    <= 1'b0;
            r_invert     <= 1'b0;
            r_throttle   <= 1'b0;
            r_thr_signed <= 1'b0;
            r_deadzone   <= V'(DZ_RESET);
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                jac_pkg::REG_CAL_MIN:    r_cal_min    <= pwdata[SAMPLE_BITS-1:0];
                jac_pkg::REG_CAL_MAX:    r_cal_max    <= pwdata[SAMPLE_BITS-1:0];
                jac_pkg::REG_CAL_ZERO:   r_cal_zero   <= pwdata[SAMPLE_BITS-1:0];
                jac_pkg::REG_CAL_PRES:   r_present    <= pwdata[0];
                jac_pkg::REG_INVERT:     r_invert     <= pwdata[0];
                jac_pkg::REG_THROTTLE:   r_throttle   <= pwdata[0];
                jac_pkg::REG_THR_SIGNED: r_thr_signed <= pwdata[0];
                jac_pkg::REG_DEADZONE:   r_deadzone   <= pwdata[FRAC_BITS:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            jac_pkg::REG_CAL_MIN:    prdata = jac_pkg::DATA_W'(r_cal_min);
            jac_pkg::REG_CAL_MAX:    prdata = jac_pkg::DATA_W'(r_cal_max);
            jac_pkg::REG_CAL_ZERO:   prdata = jac_pkg::DATA_W'(r_cal_zero);
            jac_pkg::REG_CAL_PRES:   prdata = jac_pkg::DATA_W'(r_present);
            jac_pkg::REG_INVERT:     prdata = jac_pkg::DATA_W'(r_invert);
            jac_pkg::REG_THROTTLE:   prdata = jac_pkg::DATA_W'(r_throttle);
            jac_pkg::REG_THR_SIGNED: prdata = jac_pkg::DATA_W'(r_thr_signed);
            jac_pkg::REG_DEADZONE:   prdata = jac_pkg::DATA_W'(r_deadzone);
            default:                 prdata = '0;
        endcase
    end

    jac_pkg::t_mode w_mode;
    assign w_mode.have = r_present;
    assign w_mode.inv  = r_invert;
    assign w_mode.thr  = r_throttle;
    assign w_mode.ut   = r_throttle && !r_thr_signed;

    // front
    logic           f_valid, f_zero1, f_full1, f_zero2, f_full2, f_lin;
    logic [D-1:0]   f_an1, f_ad1, f_an2, f_ad2;
    jac_pkg::t_mode f_mode;
    logic [V-1:0]   f_dz;

    jac_front #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(start && !busy),
        .i_raw(i_raw_sample), .i_min($signed(r_cal_min)), .i_max($signed(r_cal_max)),
        .i_zero($signed(r_cal_zero)), .i_mode(w_mode), .i_dz(r_deadzone),
        .o_valid(f_valid), .o_an1(f_an1), .o_ad1(f_ad1), .o_an2(f_an2), .o_ad2(f_ad2),
        .o_zero1(f_zero1), .o_full1(f_full1), .o_zero2(f_zero2), .o_full2(f_full2),
        .o_lin(f_lin), .o_mode(f_mode), .o_dz(f_dz)
    );

    // position and center ratios
    logic                 p_valid, c_valid;
    logic [FRAC_BITS-1:0] p_quot, c_quot;
    logic [P1-1:0]        p_side;
    logic [1:0]           c_side;

    jac_div #(.W(D), .Q(FRAC_BITS), .PW(P1)) u_div_pos (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(f_valid),
        .i_num(f_an1), .i_den(f_ad1), .i_side({f_zero1, f_full1, f_lin, f_mode, f_dz}),
        .o_valid(p_valid), .o_quot(p_quot), .o_side(p_side)
    );

    jac_div #(.W(D), .Q(FRAC_BITS), .PW(2)) u_div_ctr (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(f_valid),
        .i_num(f_an2), .i_den(f_ad2), .i_side({f_zero2, f_full2}),
        .o_valid(c_valid), .o_quot(c_quot), .o_side(c_side)
    );

    // side rescale setup
    logic          m_valid, m_full, m_neg;
    logic [V-1:0]  m_num, m_span, m_p;
    logic [SW-1:0] m_side;

    jac_mid #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_mid (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(p_valid && c_valid),
        .i_q1(p_quot), .i_q2(c_quot),
        .i_zero1(p_side[P1-1]), .i_full1(p_side[P1-2]),
        .i_zero2(c_side[1]), .i_full2(c_side[0]),
        .i_side(p_side[SW-1:0]),
        .o_valid(m_valid), .o_num(m_num), .o_span(m_span), .o_full(m_full),
        .o_neg(m_neg), .o_p(m_p), .o_side(m_side)
    );

    // side rescale
    logic                 s_valid;
    logic [FRAC_BITS-1:0] s_quot;
    logic [P2-1:0]        s_side;

    jac_div #(.W(V), .Q(FRAC_BITS), .PW(P2)) u_div_side (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(m_valid),
        .i_num(m_num), .i_den(m_span), .i_side({m_full, m_neg, m_p, m_side}),
        .o_valid(s_valid), .o_quot(s_quot), .o_side(s_side)
    );

    jac_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_valid), .i_q(s_quot),
        .i_full(s_side[P2-1]), .i_neg(s_side[P2-2]), .i_p(s_side[P2-3 -: V]),
        .i_mode(jac_pkg::t_mode'(s_side[V +: MW])), .i_lin(s_side[SW-1]),
        .i_dz(s_side[V-1:0]),
        .o_valid(o_valid), .o_axis(o_axis_out)
    );

endmodule
